>>> hw/rtl/hpsm_pkg.sv
`timescale 1ns / 1ps

package hpsm_pkg;

    // Default widths of the time base and of the stored speed
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int SPEED_WIDTH_DEF = 16;

    // Field and register widths
    localparam int NOW_W      = 32;
    localparam int SPD_W      = 16;
    localparam int DEB_W      = 10;
    localparam int TMO_W      = 16;
    localparam int NUM_W      = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TMO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 2'd2;

    // Register reset values
    localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 10'd50;
    localparam logic [TMO_W-1:0] STOP_TMO_RST  = 16'd10000;
    localparam logic [NUM_W-1:0] NUMERATOR_RST = 24'd150815;

    // Request kinds
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [NOW_W-1:0] now_ms;
    } hpsm_sample_t;

    typedef struct packed {
        logic [SPD_W-1:0] speed_centi_kmh;
        logic             new_reading;
        logic             edge_rejected;
        logic             stopped;
    } hpsm_result_t;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_ms;
        logic [TMO_W-1:0] stop_timeout_ms;
        logic [NUM_W-1:0] speed_numerator;
    } hpsm_cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic div_step;
        logic commit;
    } hpsm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic out_free;
    } hpsm_status_t;

endpackage

>>> hw/rtl/hpsm_ctrl.sv
`timescale 1ns / 1ps

module hpsm_ctrl
    import hpsm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_ready,
    input  hpsm_status_t status,
    output hpsm_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign sample_ready = (state_reg == ST_IDLE);

    // Sequencing: take request, evaluate, divide if needed, write result
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = CNT_LAST;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/hpsm_dp.sv
`timescale 1ns / 1ps

module hpsm_dp
    import hpsm_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  hpsm_sample_t sample,
    input  hpsm_cfg_t    cfg,
    input  hpsm_cmd_t    cmd,
    output hpsm_status_t status,
    output hpsm_result_t result,
    output logic         result_valid,
    input  logic         result_ready
);

    localparam int QX_W = (NUM_W > SPEED_WIDTH) ? NUM_W : SPEED_WIDTH;

    // Latched request
    logic                  mode_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    // Measurement state
    logic                   have_start_reg;
    logic [TIME_WIDTH-1:0]  start_time_reg;
    logic [TIME_WIDTH-1:0]  debounce_until_reg;
    logic [SPEED_WIDTH-1:0] speed_reg;

    // Evaluation results
    logic                  edge_ok_reg;
    logic                  stop_ok_reg;
    logic [TIME_WIDTH-1:0] interval_reg;

    // Divider
    logic [TIME_WIDTH-1:0] rem_reg;
    logic [NUM_W-1:0]      quo_reg;

    // Output register
    hpsm_result_t result_reg;
    logic         result_valid_reg, result_valid_next;

    logic                   edge_ok;
    logic [TIME_WIDTH-1:0]  interval;
    logic [TIME_WIDTH:0]    trial;
    logic [TIME_WIDTH:0]    div_ext;
    logic                   trial_ge;
    logic [QX_W-1:0]        q_ext;
    logic                   q_sat;
    logic [SPEED_WIDTH-1:0] speed_div;
    logic [SPEED_WIDTH-1:0] speed_new;
    logic                   fresh;
    logic                   edge_taken;

    // Debounce and interval checks on the latched request
    assign edge_ok  = (now_reg > debounce_until_reg);
    assign interval = now_reg - start_time_reg;

    assign status.need_div = (mode_reg == MODE_EDGE) && edge_ok && have_start_reg;
    assign status.out_free = !result_valid_reg || result_ready;

    // Restoring divide step, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign div_ext  = {1'b0, interval_reg};
    assign trial_ge = (trial >= div_ext);

    // Saturate the quotient; a zero interval saturates too
    assign q_ext     = QX_W'(quo_reg);
    assign q_sat     = ((q_ext >> SPEED_WIDTH) != '0) || (interval_reg == '0);
    assign speed_div = q_sat ? '1 : SPEED_WIDTH'(q_ext);

    // Result selection at commit
    assign edge_taken = (mode_reg == MODE_EDGE) && edge_ok_reg;
    assign fresh      = edge_taken && have_start_reg;

    always_comb
    begin
        speed_new = speed_reg;
        if (fresh)
        begin
            speed_new = speed_div;
        end
        else if ((mode_reg == MODE_POLL) && stop_ok_reg)
        begin
            speed_new = '0;
        end
    end

    // Request latch, evaluation and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= sample.mode;
            now_reg  <= TIME_WIDTH'(sample.now_ms);
        end
        if (cmd.eval)
        begin
            edge_ok_reg  <= edge_ok;
            stop_ok_reg  <= (interval >= TIME_WIDTH'(cfg.stop_timeout_ms));
            interval_reg <= interval;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= cfg.speed_numerator;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? TIME_WIDTH'(trial - div_ext) : TIME_WIDTH'(trial);
            quo_reg <= {quo_reg[NUM_W-2:0], trial_ge};
        end
        if (cmd.commit)
        begin
            result_reg.speed_centi_kmh <= SPD_W'(speed_new);
            result_reg.new_reading     <= fresh;
            result_reg.edge_rejected   <= (mode_reg == MODE_EDGE) && !edge_ok_reg;
            result_reg.stopped         <= (mode_reg == MODE_POLL) && stop_ok_reg;
        end
    end

    // Measurement state updates at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_start_reg     <= 1'b0;
            start_time_reg     <= '0;
            debounce_until_reg <= '0;
            speed_reg          <= '0;
        end
        else if (cmd.commit)
        begin
            speed_reg <= speed_new;
            if (edge_taken)
            begin
                have_start_reg     <= 1'b1;
                start_time_reg     <= now_reg;
                debounce_until_reg <= now_reg + TIME_WIDTH'(cfg.debounce_ms);
            end
        end
    end

    // Output valid
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.commit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

>>> hw/rtl/hall_pulse_speed_meter_top.sv
`timescale 1ns / 1ps
// Channel   Handshake                    Payload
// sample    sample_valid / sample_ready  hpsm_sample_t: mode, now_ms
// result    result_valid / result_ready  hpsm_result_t: speed, new_reading,
//                                        edge_rejected, stopped
// config    cfg_we                       cfg_index, cfg_data
//
// An edge that yields a reading passes from accept through the evaluate state,
// 24 restoring divide steps (one per numerator bit) and the write state back
// to idle; other requests go through evaluate and write only. Reset clears the
// measurement state and output valid and sets the config registers to defaults.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its result waits in the write step until that slot frees.

module hall_pulse_speed_meter_top
    import hpsm_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  hpsm_sample_t          sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output hpsm_result_t          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    hpsm_cfg_t    cfg_reg;
    hpsm_cmd_t    cmd;
    hpsm_status_t status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
            cfg_reg.stop_timeout_ms <= STOP_TMO_RST;
            cfg_reg.speed_numerator <= NUMERATOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:  cfg_reg.debounce_ms     <= cfg_data[DEB_W-1:0];
                CFG_STOP_TMO:  cfg_reg.stop_timeout_ms <= cfg_data[TMO_W-1:0];
                CFG_NUMERATOR: cfg_reg.speed_numerator <= cfg_data[NUM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    hpsm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    hpsm_dp #(
        .TIME_WIDTH  (TIME_WIDTH),
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // One request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("request taken while another is in flight");

    // At most one status flag per result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            $countones({result.new_reading, result.edge_rejected, result.stopped}) <= 1)
        else $error("more than one result flag set");

    // A stop poll always reports zero speed
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stopped |-> result.speed_centi_kmh == '0)
        else $error("stopped result with nonzero speed");

    // The controller never commits over a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !result_valid || result_ready)
        else $error("result overwritten before it was taken");

endmodule
